// File: hw/rtl/nir_pkg.sv
// ============================================================================
// nir_pkg - shared types and constants of the NEC IR frame decoder
// Holds configuration reset values, register indexes and the class word that
// travels from the front classifier to the back frame sequencer.
// ============================================================================
package nir_pkg;

    // Frame and queue geometry defaults
    localparam int FRAME_BITS_DEFAULT  = 32;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Configuration port geometry
    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int STAMP_W     = 32;
    localparam int WORD_W      = 32;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LEADER_MIN = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEADER_MAX = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_MIN    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_MAX   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_MIN    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_MAX    = 3'd5;

    // Register reset values, microseconds
    localparam logic [CFG_W-1:0] LEADER_MIN_RESET = 16'd13000;
    localparam logic [CFG_W-1:0] LEADER_MAX_RESET = 16'd14000;
    localparam logic [CFG_W-1:0] BIT_MIN_RESET    = 16'd844;
    localparam logic [CFG_W-1:0] ZERO_MAX_RESET   = 16'd1500;
    localparam logic [CFG_W-1:0] ONE_MIN_RESET    = 16'd2000;
    localparam logic [CFG_W-1:0] BIT_MAX_RESET    = 16'd2531;

    // Sum that a byte and its complement must reach
    localparam logic [8:0] PAIR_SUM = 9'd255;

    // Interval class of one edge, decided against every window at once
    typedef struct packed {
        logic leader_ok;
        logic bit_zero;
        logic bit_one;
    } nir_class_t;

    // One result item
    typedef struct packed {
        logic       frame_done;
        logic       frame_ok;
        logic [7:0] address;
        logic [7:0] address_inverse;
        logic [7:0] command_code;
        logic [7:0] command_inverse;
        logic       timing_error;
    } nir_result_t;

endpackage

// File: hw/rtl/nir_front.sv
// ============================================================================
// nir_front - edge interval classifier
// Holds the configuration windows and the previous stamp, forms the saturated
// interval of each accepted edge and pushes its class into the queue.
// ============================================================================
module nir_front
    import nir_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [STAMP_W-1:0]     edge_time,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   queue_full,
    output logic                   push,
    output nir_class_t             push_class
);

    logic [CFG_W-1:0]   leader_min_reg;
    logic [CFG_W-1:0]   leader_max_reg;
    logic [CFG_W-1:0]   bit_min_reg;
    logic [CFG_W-1:0]   zero_max_reg;
    logic [CFG_W-1:0]   one_min_reg;
    logic [CFG_W-1:0]   bit_max_reg;
    logic [STAMP_W-1:0] last_stamp_reg;

    logic [STAMP_W-1:0] gap_full;
    logic [CFG_W-1:0]   gap;
    logic               in_range;
    logic               is_zero;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    // Down-counting timer: elapsed time is previous minus current, saturated
    assign gap_full = last_stamp_reg - edge_time;
    assign gap      = (|gap_full[STAMP_W-1:CFG_W]) ? {CFG_W{1'b1}} : gap_full[CFG_W-1:0];

    assign in_range = (gap > bit_min_reg) && (gap < bit_max_reg);
    assign is_zero  = in_range && (gap < zero_max_reg);

    always_comb
    begin
        push_class.leader_ok = (gap > leader_min_reg) && (gap < leader_max_reg);
        push_class.bit_zero  = is_zero;
        // the zero window wins where the two overlap
        push_class.bit_one   = in_range && (gap > one_min_reg) && !is_zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leader_min_reg <= LEADER_MIN_RESET;
            leader_max_reg <= LEADER_MAX_RESET;
            bit_min_reg    <= BIT_MIN_RESET;
            zero_max_reg   <= ZERO_MAX_RESET;
            one_min_reg    <= ONE_MIN_RESET;
            bit_max_reg    <= BIT_MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEADER_MIN: leader_min_reg <= cfg_data;
                CFG_LEADER_MAX: leader_max_reg <= cfg_data;
                CFG_BIT_MIN:    bit_min_reg    <= cfg_data;
                CFG_ZERO_MAX:   zero_max_reg   <= cfg_data;
                CFG_ONE_MIN:    one_min_reg    <= cfg_data;
                CFG_BIT_MAX:    bit_max_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_stamp_reg <= '0;
        end
        else if (push)
        begin
            last_stamp_reg <= edge_time;
        end
    end

endmodule

// File: hw/rtl/nir_queue.sv
// ============================================================================
// nir_queue - short class queue
// Register FIFO that decouples the classifier from the frame sequencer.
// ============================================================================
module nir_queue
    import nir_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  nir_class_t push_class,
    input  logic       pop,
    output nir_class_t pop_class,
    output logic       full,
    output logic       empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    nir_class_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);
    assign pop_class = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_class;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/nir_back.sv
// ============================================================================
// nir_back - frame sequencer
// Walks the edge counter, shifts in data bits and registers one result per
// class taken from the queue.
// ============================================================================
module nir_back
    import nir_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        queue_empty,
    input  nir_class_t  pop_class,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output nir_result_t result
);

    localparam int IDX_W = $clog2(FRAME_BITS + 2);
    localparam logic [IDX_W-1:0] IDX_START  = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_LEADER = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_DATA   = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_BITS + 1);

    logic [IDX_W-1:0]      edge_index_reg;
    logic [IDX_W-1:0]      edge_index_next;
    logic [FRAME_BITS-1:0] bit_shift_reg;
    logic [FRAME_BITS-1:0] bit_shift_next;
    logic [FRAME_BITS-1:0] shifted;
    logic [WORD_W-1:0]     word;
    logic                  out_valid_reg;
    nir_result_t           result_reg;
    nir_result_t           result_next;

    // Take a class whenever the output register is empty or being emptied
    assign pop       = !queue_empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    assign shifted = {bit_shift_reg[FRAME_BITS-2:0], pop_class.bit_one};
    assign word    = WORD_W'(shifted);

    always_comb
    begin
        edge_index_next = edge_index_reg;
        bit_shift_next  = bit_shift_reg;
        result_next     = '0;
        if (edge_index_reg == IDX_START || edge_index_reg > IDX_LAST)
        begin
            bit_shift_next  = '0;
            edge_index_next = IDX_LEADER;
        end
        else if (edge_index_reg == IDX_LEADER)
        begin
            if (pop_class.leader_ok)
            begin
                edge_index_next = IDX_DATA;
            end
            else
            begin
                edge_index_next          = IDX_START;
                result_next.timing_error = 1'b1;
            end
        end
        else if (pop_class.bit_zero || pop_class.bit_one)
        begin
            bit_shift_next  = shifted;
            edge_index_next = edge_index_reg + 1'b1;
            if (edge_index_reg == IDX_LAST)
            begin
                edge_index_next             = IDX_START;
                result_next.frame_done      = 1'b1;
                result_next.address         = word[31:24];
                result_next.address_inverse = word[23:16];
                result_next.command_code    = word[15:8];
                result_next.command_inverse = word[7:0];
                result_next.frame_ok =
                    (({1'b0, word[31:24]} + {1'b0, word[23:16]}) == PAIR_SUM) &&
                    (({1'b0, word[15:8]}  + {1'b0, word[7:0]})   == PAIR_SUM);
            end
        end
        else
        begin
            edge_index_next          = IDX_START;
            result_next.timing_error = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_index_reg <= '0;
            bit_shift_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                edge_index_reg <= edge_index_next;
                bit_shift_reg  <= bit_shift_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// File: hw/rtl/nec_ir_frame_decoder.sv
// ============================================================================
// nec_ir_frame_decoder - NEC infrared frame decoder, top level
// Turns stamped falling edges of an IR receiver into one result per edge:
// leader and bit timing checks, 32-bit frame assembly and complement check.
// ============================================================================
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  input    | in_valid / in_ready   | edge_time
//  output   | out_valid / out_ready | frame_done frame_ok address address_inverse
//           |                       | command_code command_inverse timing_error
//  config   | cfg_we                | cfg_index cfg_data
//
//  One edge is accepted per cycle while the queue has room; each edge's class
//  is registered in the queue, then its result in the output register.
//  The front classifier forms the interval and tests every window in the
//  accept cycle; the back sequencer advances the edge counter one class per
//  cycle unless a stalled output holds it. The queue between them sets
//  the acceptance limit: in_ready drops only when it is full, which happens
//  once out_ready stalls long enough. Reset restores the window registers and
//  clears stamp, counter and queue; no clearing pass is needed.
//
module nec_ir_frame_decoder
    import nir_pkg::*;
#(
    parameter int FRAME_BITS  = FRAME_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [STAMP_W-1:0]     edge_time,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   frame_done,
    output logic                   frame_ok,
    output logic [7:0]             address,
    output logic [7:0]             address_inverse,
    output logic [7:0]             command_code,
    output logic [7:0]             command_inverse,
    output logic                   timing_error,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    logic        push;
    logic        pop;
    logic        queue_full;
    logic        queue_empty;
    nir_class_t  push_class;
    nir_class_t  pop_class;
    nir_result_t result;

    // Front: accept an edge whenever the queue has room, classify it
    nir_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .edge_time  (edge_time),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .push_class (push_class)
    );

    // Queue: hold classes while the output side stalls
    nir_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_class (push_class),
        .pop        (pop),
        .pop_class  (pop_class),
        .full       (queue_full),
        .empty      (queue_empty)
    );

    // Back: advance the frame and register one transaction per class
    nir_back #(
        .FRAME_BITS (FRAME_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .pop_class   (pop_class),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result      (result)
    );

    assign frame_done      = result.frame_done;
    assign frame_ok        = result.frame_ok;
    assign address         = result.address;
    assign address_inverse = result.address_inverse;
    assign command_code    = result.command_code;
    assign command_inverse = result.command_inverse;
    assign timing_error    = result.timing_error;

endmodule

// File: hw/rtl/nir_checker.sv
// ============================================================================
// nir_checker - port-level checks of the NEC IR frame decoder
// Watches the output channel and the meaning of the result fields.
// ============================================================================
module nir_checker
    import nir_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       frame_done,
    input logic       frame_ok,
    input logic [7:0] address,
    input logic [7:0] address_inverse,
    input logic [7:0] command_code,
    input logic [7:0] command_inverse,
    input logic       timing_error
);

    // Hold a stalled output transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_done) &&
        $stable(address) && $stable(command_code) && $stable(timing_error))
        else $error("stalled output transaction changed");

    // Bytes and check flag stay zero unless a frame completed
    a_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_done |-> !frame_ok && address == 8'd0 &&
        address_inverse == 8'd0 && command_code == 8'd0 && command_inverse == 8'd0)
        else $error("frame fields set without a completed frame");

    // A completed frame never carries a timing error
    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> !timing_error)
        else $error("completed frame flagged a timing error");

    // frame_ok agrees with the complement pairs
    a_ok_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> frame_ok ==
        ((({1'b0, address} + {1'b0, address_inverse}) == PAIR_SUM) &&
         (({1'b0, command_code} + {1'b0, command_inverse}) == PAIR_SUM)))
        else $error("frame_ok disagrees with the complement check");

endmodule

bind nec_ir_frame_decoder nir_checker u_nir_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .frame_done      (frame_done),
    .frame_ok        (frame_ok),
    .address         (address),
    .address_inverse (address_inverse),
    .command_code    (command_code),
    .command_inverse (command_inverse),
    .timing_error    (timing_error)
);
